### hw/rtl/blws_pkg.sv
// Shared types and constants for the bounded list with search.
// No dependencies; used by blws_cell and bounded_list_with_search.
package blws_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int CMD_W            = 3;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FLUSH
    } state_t;

    // Per-cycle update broadcast to every cell
    typedef struct packed {
        logic shift_right;  // insert at front
        logic shift_left;   // remove front
        logic write_back;   // insert at back, cell at index count takes the value
    } ctrl_t;

endpackage

### hw/rtl/blws_cell.sv
// One list position: holds one entry and one stage of the search probe.
// Depends on blws_pkg.
module blws_cell #(
    parameter int CAPACITY = blws_pkg::DEFAULT_CAPACITY,
    parameter int INDEX    = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blws_pkg::ctrl_t                   ctrl,
    input  blws_pkg::value_t                  wr_value,
    input  blws_pkg::value_t                  key,
    input  logic [$clog2(CAPACITY+1)-1:0]     live_count,
    input  blws_pkg::value_t                  prev_data,
    input  blws_pkg::value_t                  next_data,
    output blws_pkg::value_t                  data,
    input  logic                              probe_in,
    input  logic                              found_in,
    output logic                              probe_out,
    output logic                              found_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] IDX = CW'(INDEX);

    blws_pkg::value_t data_reg;
    blws_pkg::value_t data_next;
    logic             probe_reg;
    logic             found_reg;
    logic             found_next;
    logic             live;

    assign live = (IDX < live_count);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_right)
        begin
            data_next = prev_data;
        end
        else if (ctrl.shift_left)
        begin
            data_next = next_data;
        end
        else if (ctrl.write_back && (live_count == IDX))
        begin
            data_next = wr_value;
        end
    end

    assign found_next = found_in | (live && (data_reg == key));

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        found_reg <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_in;
        end
    end

    assign data      = data_reg;
    assign probe_out = probe_reg;
    assign found_out = found_reg;

endmodule

### hw/rtl/bounded_list_with_search.sv
// Top level of the bounded list: command decode, result register, cell row.
// Depends on blws_pkg and blws_cell.
//
// Usage
//   Command channel: cmd_valid / cmd_stall carry command and value. A transfer
//   happens on a rising edge with cmd_valid high and cmd_stall low.
//   Result channel: res_valid / res_stall carry status, found and count, one
//   result per command, in command order.
//   List entries sit in a row of CAPACITY cells, front entry in cell 0.
//   Insert front shifts the row right, remove front shifts it left, insert
//   back writes the cell at index count; all finish in the transfer cycle and
//   the result is valid on the next cycle.
//   Search sends a probe token down the row, one cell per cycle; each live
//   cell ORs its compare into the travelling found bit. The result is
//   registered once the probe has left the last cell and the slot is free;
//   other commands sustain one per cycle unless a result waits under res_stall.
//   While a search runs, cmd_stall is high. A new command is also held off
//   while a result sits unread under res_stall; the result register holds.
//   Reset empties the list and drops any pending result; entry storage is not
//   cleared and needs no sweep.
module bounded_list_with_search #(
    parameter int CAPACITY = blws_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [blws_pkg::CMD_W-1:0]        command,
    input  blws_pkg::value_t                  value,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [blws_pkg::STATUS_W-1:0]     status,
    output logic                              found,
    output logic [blws_pkg::COUNT_W-1:0]      count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    blws_pkg::state_t state_reg;
    blws_pkg::state_t state_next;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    blws_pkg::value_t key_reg;
    blws_pkg::value_t key_next;
    logic             launch_reg;
    logic             launch_next;
    logic             hold_found_reg;
    logic             hold_found_next;

    // result register
    logic                            res_valid_reg;
    logic                            res_valid_next;
    logic [blws_pkg::STATUS_W-1:0]   status_reg;
    logic [blws_pkg::STATUS_W-1:0]   status_next;
    logic                            found_reg;
    logic                            found_next;
    logic [blws_pkg::COUNT_W-1:0]    count_out_reg;
    logic [blws_pkg::COUNT_W-1:0]    count_out_next;

    blws_pkg::ctrl_t  ctrl;
    logic             out_free;
    logic             accept;

    blws_pkg::value_t cell_data [CAPACITY];
    logic [CAPACITY:0] probe_chain;
    logic [CAPACITY:0] found_chain;

    // Result slot is free if empty or being taken this cycle
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = !((state_reg == blws_pkg::S_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;

    assign probe_chain[0] = launch_reg;
    assign found_chain[0] = 1'b0;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        launch_next     = 1'b0;
        hold_found_next = hold_found_reg;
        ctrl            = '0;
        res_valid_next  = res_valid_reg && res_stall;
        status_next     = status_reg;
        found_next      = found_reg;
        count_out_next  = count_out_reg;

        case (state_reg)
            blws_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (command == blws_pkg::CMD_SEARCH)
                    begin
                        key_next    = value;
                        launch_next = 1'b1;
                        state_next  = blws_pkg::S_SEARCH;
                    end
                    else
                    begin
                        status_next = blws_pkg::ST_DONE;
                        case (command)
                            blws_pkg::CMD_INS_FRONT:
                            begin
                                if (count_reg == FULL_COUNT)
                                begin
                                    status_next = blws_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ctrl.shift_right = 1'b1;
                                    count_next       = CW'(count_reg + 1'b1);
                                end
                            end
                            blws_pkg::CMD_INS_BACK:
                            begin
                                if (count_reg == FULL_COUNT)
                                begin
                                    status_next = blws_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ctrl.write_back = 1'b1;
                                    count_next      = CW'(count_reg + 1'b1);
                                end
                            end
                            blws_pkg::CMD_REM_FRONT:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_next = blws_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    ctrl.shift_left = 1'b1;
                                    count_next      = CW'(count_reg - 1'b1);
                                end
                            end
                            blws_pkg::CMD_CLEAR:
                            begin
                                count_next = '0;
                            end
                            default:
                            begin
                                // unused codes: no change
                            end
                        endcase
                        res_valid_next = 1'b1;
                        found_next     = 1'b0;
                        count_out_next = blws_pkg::COUNT_W'(count_next);
                    end
                end
            end

            blws_pkg::S_SEARCH:
            begin
                // probe has left the last cell
                if (probe_chain[CAPACITY])
                begin
                    if (out_free)
                    begin
                        res_valid_next = 1'b1;
                        status_next    = blws_pkg::ST_DONE;
                        found_next     = found_chain[CAPACITY];
                        count_out_next = blws_pkg::COUNT_W'(count_reg);
                        state_next     = blws_pkg::S_IDLE;
                    end
                    else
                    begin
                        hold_found_next = found_chain[CAPACITY];
                        state_next      = blws_pkg::S_FLUSH;
                    end
                end
            end

            blws_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = blws_pkg::ST_DONE;
                    found_next     = hold_found_reg;
                    count_out_next = blws_pkg::COUNT_W'(count_reg);
                    state_next     = blws_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = blws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blws_pkg::S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        hold_found_reg <= hold_found_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        count_out_reg  <= count_out_next;
    end

    // Row of cells: cell 0 is the front of the list
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        blws_pkg::value_t prev_d;
        blws_pkg::value_t next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = value;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        blws_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_value   (value),
            .key        (key_reg),
            .live_count (count_reg),
            .prev_data  (prev_d),
            .next_data  (next_d),
            .data       (cell_data[i]),
            .probe_in   (probe_chain[i]),
            .found_in   (found_chain[i]),
            .probe_out  (probe_chain[i+1]),
            .found_out  (found_chain[i+1])
        );
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_out_reg;

endmodule

### verif/blws_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the bounded list: shadow ring of list entries and queue of predicted results.
// Depends on blws_pkg for widths, command and status codes.
package blws_tb_pkg;

    import blws_pkg::*;

    localparam int LIST_DEPTH = DEFAULT_CAPACITY;

    // Codes 5 to 7 are not decoded by the block and must act as no-ops
    localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    class list_scoreboard;

        value_t         ring[LIST_DEPTH];
        int unsigned    head;
        int unsigned    held;
        list_result_t   awaited[$];
        int             failures;

        function new();
            head     = 0;
            held     = 0;
            failures = 0;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Apply one accepted command transfer to the shadow list and queue its result
        function void note_command(logic [CMD_W-1:0] cmd, value_t val);
            list_result_t r;
            r.status = ST_DONE;
            r.found  = 1'b0;
            case (cmd)
                CMD_INS_FRONT:
                    if (held >= LIST_DEPTH) r.status = ST_FULL;
                    else
                    begin
                        head       = (head + LIST_DEPTH - 1) % LIST_DEPTH;
                        ring[head] = val;
                        held++;
                    end
                CMD_INS_BACK:
                    if (held >= LIST_DEPTH) r.status = ST_FULL;
                    else
                    begin
                        ring[(head + held) % LIST_DEPTH] = val;
                        held++;
                    end
                CMD_REM_FRONT:
                    if (held == 0) r.status = ST_EMPTY;
                    else
                    begin
                        head = (head + 1) % LIST_DEPTH;
                        held--;
                    end
                CMD_CLEAR:
                begin
                    head = 0;
                    held = 0;
                end
                CMD_SEARCH:
                    for (int unsigned k = 0; k < held; k++)
                        if (ring[(head + k) % LIST_DEPTH] == val) r.found = 1'b1;
                default: ;
            endcase
            r.count = COUNT_W'(held);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic found,
                                   logic [COUNT_W-1:0] count);
            list_result_t e;
            if (awaited.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                failures++;
            end
            if (found !== e.found)
            begin
                $error("found: expected %0d, got %0d", e.found, found);
                failures++;
            end
            if (count !== e.count)
            begin
                $error("count: expected %0d, got %0d", e.count, count);
                failures++;
            end
        endfunction

    endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for bounded_list_with_search: clock, reset, command driver, result sink.
// Depends on blws_pkg, blws_tb_pkg and the RTL of the block.
module tb_top;

    import blws_pkg::*;
    import blws_tb_pkg::*;

    localparam int  RANDOM_ITEMS  = 720;
    localparam int  HOLD_CYCLES   = 200;      // long receiver hold-off
    localparam int  DRAIN_CYCLES  = LIST_DEPTH + 8;
    localparam time TIMEOUT_NS    = 3_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic [CMD_W-1:0]     command   = '0;
    value_t               value     = '0;
    logic                 res_stall = 1'b0;
    logic                 cmd_stall;
    logic                 res_valid;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [COUNT_W-1:0]   count;

    list_scoreboard sb = new();

    // Idle rates in percent; the driver moves these between phases
    int tx_idle_pct = 19;
    int rx_idle_pct = 66;

    // Hold-off requests: driver bumps hold_asks, the sink process serves them
    int hold_asks   = 0;
    int hold_served = 0;
    int hold_left   = 0;

    // Small pool of values so that searches hit held entries often
    value_t value_pool[8];

    bounded_list_with_search #(
        .CAPACITY (LIST_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .found     (found),
        .count     (count)
    );

    always #5 clk = ~clk;

    // Result side stall: random at the current rate, or held high for a long
    // stretch when asked, so that the block backs up onto the command side.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
            res_stall  <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Sample at the rising edge: values seen here are those before the edge
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(status, found, count);

    // One command transfer. Entered and left at a falling edge; valid is left
    // high so that back-to-back transfers never drop it within one step.
    task automatic send_command(logic [CMD_W-1:0] cmd, value_t val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= cmd;
        value     <= val;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(cmd, val);
        @(negedge clk);
    endtask

    function automatic value_t pick_value();
        if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
        return value_t'($urandom);
    endfunction

    // Weighted command choice; filling leans towards inserts, draining towards
    // removes, so that both the full and the empty corners are visited often.
    function automatic logic [CMD_W-1:0] pick_command(bit filling);
        int r;
        int lim_front;
        int lim_back;
        int lim_rem;
        r         = $urandom_range(99);
        lim_front = filling ? 30 : 10;
        lim_back  = filling ? 60 : 20;
        lim_rem   = filling ? 70 : 60;
        if (r < lim_front)   return CMD_INS_FRONT;
        if (r < lim_back)    return CMD_INS_BACK;
        if (r < lim_rem)     return CMD_REM_FRONT;
        if (r < lim_rem + 2) return CMD_CLEAR;
        if (r < lim_rem + 5)
        begin
            case ($urandom_range(2))
                0:       return CMD_UNUSED_5;
                1:       return CMD_UNUSED_6;
                default: return CMD_UNUSED_7;
            endcase
        end
        return CMD_SEARCH;
    endfunction

    task automatic run_directed();
        // empty-list corners: remove ignored, search finds nothing
        send_command(CMD_REM_FRONT, value_t'(32'sh1234_5678));
        send_command(CMD_SEARCH,    value_t'(0));
        // extremes of the value field at both ends of the list
        send_command(CMD_INS_FRONT, value_t'(32'sh7FFF_FFFF));
        send_command(CMD_INS_BACK,  value_t'(32'sh8000_0000));
        send_command(CMD_INS_FRONT, value_t'(0));
        send_command(CMD_INS_BACK,  value_t'(-1));
        send_command(CMD_SEARCH,    value_t'(32'sh7FFF_FFFF));
        send_command(CMD_SEARCH,    value_t'(32'sh8000_0000));
        send_command(CMD_SEARCH,    value_t'(1));
        // undecoded codes leave the list alone and report nothing found
        send_command(CMD_UNUSED_5,  value_t'(-1));
        send_command(CMD_UNUSED_6,  value_t'(0));
        send_command(CMD_UNUSED_7,  value_t'(32'sh7FFF_FFFF));
        send_command(CMD_REM_FRONT, value_t'(0));
        // fill to capacity, then inserts are dropped as full
        for (int k = 0; k < LIST_DEPTH - 3; k++)
            send_command((k % 2 == 0) ? CMD_INS_BACK : CMD_INS_FRONT, value_t'($urandom));
        send_command(CMD_INS_FRONT, value_t'(5));
        send_command(CMD_INS_BACK,  value_t'(6));
        // search of the full list for -1, which the fill has left mid-list
        send_command(CMD_SEARCH,    value_t'(-1));
        send_command(CMD_CLEAR,     value_t'(-1));
        send_command(CMD_SEARCH,    value_t'(-1));
    endtask

    task automatic run_random(int n);
        bit filling;
        int run_left;
        logic [CMD_W-1:0] cmd;
        filling  = 1'b1;
        run_left = 24 + $urandom_range(24);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3)
            begin
                tx_idle_pct = 66;
                rx_idle_pct = 19;
            end
            if (i == (2 * n) / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 60)
                hold_asks++;
            // pause the sender until the result queue has fully drained
            if (i == n / 2)
            begin
                cmd_valid <= 1'b0;
                do
                    @(negedge clk);
                while (sb.outstanding() != 0);
            end
            if (run_left == 0)
            begin
                filling  = ~filling;
                run_left = 24 + $urandom_range(24);
            end
            run_left--;
            cmd = pick_command(filling);
            send_command(cmd, pick_value());
        end
    endtask

    initial
    begin
        value_pool[0] = value_t'(32'sh7FFF_FFFF);
        value_pool[1] = value_t'(32'sh8000_0000);
        value_pool[2] = value_t'(0);
        value_pool[3] = value_t'(-1);
        for (int k = 4; k < 8; k++)
            value_pool[k] = value_t'($urandom);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        cmd_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/blws_pkg.sv
hw/rtl/blws_cell.sv
hw/rtl/bounded_list_with_search.sv
verif/blws_tb_pkg.sv
verif/tb_top.sv
